// ===== hdl/tiie_pkg.sv =====
`timescale 1ns / 1ps

package tiie_pkg;

    localparam int XLEN       = 32;
    localparam int IP_W       = 16;
    localparam int FLAG_W     = 2;
    localparam int NREGS      = 8;
    localparam int DATA_WORDS = 256;
    localparam int DATA_BASE  = 16384;
    localparam int IDX_W      = $clog2(DATA_WORDS);
    localparam int CNT_W      = $clog2(XLEN);
    localparam int IN_W       = 64;
    localparam int OUT_W      = 56;

    localparam logic [7:0] OP_MOVE = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_SUB  = 8'd3;
    localparam logic [7:0] OP_MUL  = 8'd4;
    localparam logic [7:0] OP_DIV  = 8'd5;
    localparam logic [7:0] OP_AND  = 8'd6;
    localparam logic [7:0] OP_OR   = 8'd7;
    localparam logic [7:0] OP_NOT  = 8'd8;
    localparam logic [7:0] OP_CMP  = 8'd9;
    localparam logic [7:0] OP_JMP  = 8'd10;
    localparam logic [7:0] OP_IN   = 8'd11;
    localparam logic [7:0] OP_OUT  = 8'd12;

    localparam logic [FLAG_W-1:0] FLAG_EQ   = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_GT   = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_LESS = 2'b11;

    localparam logic [3:0] JC_ALWAYS = 4'd0;
    localparam logic [3:0] JC_EQ     = 4'd1;
    localparam logic [3:0] JC_GT     = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_MEM,
        ST_PREP,
        ST_CALC,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic ld_in;
        logic sel_b;
        logic ld_a;
        logic ld_b;
        logic ld_idx;
        logic calc_start;
        logic calc_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_calc;
        logic calc_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hdl/toy_isa_instruction_execute_unit.sv =====
`timescale 1ns / 1ps

// executes one 32-bit instruction per input word against eight registers and a
// 256-word data memory; one result word per instruction. each instruction passes
// through two register reads over one read port, one memory read, a prepare step
// and commit; mul and div also iterate before commit, because the shift-add
// multiplier and the restoring divider each iterate one bit per cycle over 32
// bits. a new word is accepted once the previous one has committed, while its
// result still waits in the output register.
module toy_isa_instruction_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instruction, input_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // next_ip, flag_value, out_valid, out_value, halted, error
);

    tiie_pkg::ctrl_cmd_t cmd;
    tiie_pkg::dp_stat_t  stat;

    tiie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tiie_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== hdl/tiie_ram.sv =====
`timescale 1ns / 1ps

module tiie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tiie_ctrl.sv =====
`timescale 1ns / 1ps

module tiie_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tiie_pkg::dp_stat_t   stat,
    output tiie_pkg::ctrl_cmd_t  cmd
);

    tiie_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tiie_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tiie_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tiie_pkg::ST_RD_A;
                end
            end
            tiie_pkg::ST_RD_A:   state_next = tiie_pkg::ST_RD_B;
            tiie_pkg::ST_RD_B:   state_next = tiie_pkg::ST_MEM;
            tiie_pkg::ST_MEM:    state_next = tiie_pkg::ST_PREP;
            tiie_pkg::ST_PREP:
            begin
                state_next = stat.need_calc ? tiie_pkg::ST_CALC : tiie_pkg::ST_COMMIT;
            end
            tiie_pkg::ST_CALC:
            begin
                if (stat.calc_last)
                begin
                    state_next = tiie_pkg::ST_COMMIT;
                end
            end
            tiie_pkg::ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = tiie_pkg::ST_IDLE;
                end
            end
            default:             state_next = tiie_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            tiie_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.ld_in  = s_tvalid;
            end
            tiie_pkg::ST_RD_A:   cmd.ld_a = 1'b1;
            tiie_pkg::ST_RD_B:
            begin
                cmd.sel_b = 1'b1;
                cmd.ld_b  = 1'b1;
            end
            tiie_pkg::ST_MEM:    cmd.ld_idx = 1'b1;
            tiie_pkg::ST_PREP:   cmd.calc_start = 1'b1;
            tiie_pkg::ST_CALC:   cmd.calc_step = 1'b1;
            tiie_pkg::ST_COMMIT: cmd.commit = stat.out_free;
            default:             cmd = '0;
        endcase
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == tiie_pkg::ST_RD_A)
        else $error("accepted word did not start register read");
    a_calc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tiie_pkg::ST_CALC && !stat.calc_last) |=>
        state_reg == tiie_pkg::ST_CALC)
        else $error("iteration left early");
    a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tiie_pkg::ST_COMMIT && !stat.out_free) |=>
        state_reg == tiie_pkg::ST_COMMIT)
        else $error("commit dropped while output busy");

endmodule

// ===== hdl/tiie_dp.sv =====
`timescale 1ns / 1ps

module tiie_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tiie_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tiie_pkg::OUT_W-1:0]   m_tdata,
    input  tiie_pkg::ctrl_cmd_t          cmd,
    output tiie_pkg::dp_stat_t           stat
);

    localparam int XL = tiie_pkg::XLEN;
    localparam int IW = tiie_pkg::IDX_W;

    logic [XL-1:0] ins_reg, inval_reg, a_reg, b_reg;
    logic [XL-1:0] gpr_reg [tiie_pkg::NREGS];
    logic [tiie_pkg::IP_W-1:0] ip_reg;
    logic [tiie_pkg::FLAG_W-1:0] flag_reg;
    logic [IW-1:0] idx_reg;
    logic idx_ok_reg;
    logic [tiie_pkg::DATA_WORDS-1:0] vld_reg;
    logic [XL-1:0] mcand_reg, mplier_reg, acc_reg;
    logic [XL-1:0] rem_reg, quo_reg, dvs_reg;
    logic neg_reg;
    logic [tiie_pkg::CNT_W-1:0] cnt_reg;
    logic m_tvalid_reg;
    logic [tiie_pkg::OUT_W-1:0] out_reg;

    logic [7:0] op;
    logic [3:0] ra, rb, rsel, rm1;
    logic [XL-1:0] imm, rdata, iv, ram_q, mem_val, src;
    logic signed [XL:0] d_s;
    logic idx_ok_n;
    logic [IW-1:0] idx_n;
    logic ra_bad, rb_bad, use_a;
    logic [XL:0] div_rs;
    logic [XL-1:0] div_res, a_abs, s_abs;

    logic err, halt, ov, wr_en, mw_en, take;
    logic [XL-1:0] wr_val, mw_val, oval;
    logic [tiie_pkg::IP_W-1:0] nip;
    logic [tiie_pkg::FLAG_W-1:0] flag_n;

    assign op  = ins_reg[31:24];
    assign ra  = ins_reg[23:20];
    assign rb  = ins_reg[19:16];
    assign imm = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign ra_bad = ra > 4'd8;
    assign rb_bad = rb > 4'd8;
    assign use_a  = (op == tiie_pkg::OP_MOVE) && (rb >= 4'd1) && (rb <= 4'd4);

    // register file read port
    assign rsel  = cmd.sel_b ? rb : ra;
    assign rm1   = rsel - 4'd1;
    assign rdata = (rsel >= 4'd1 && rsel <= 4'd8) ? gpr_reg[rm1[2:0]] : '0;

    // word index, truncating toward zero
    assign iv  = use_a ? a_reg : b_reg;
    assign d_s = $signed({iv[XL-1], iv}) - $signed((XL+1)'(tiie_pkg::DATA_BASE));
    assign idx_ok_n = (d_s >= -$signed((XL+1)'(1)))
                   && (d_s <= $signed((XL+1)'(2 * tiie_pkg::DATA_WORDS - 1)));
    assign idx_n = (d_s == -$signed((XL+1)'(1))) ? '0 : d_s[IW:1];

    tiie_ram #(.WIDTH(XL), .DEPTH(tiie_pkg::DATA_WORDS)) u_mem (
        .clk   (clk),
        .we    (mw_en),
        .waddr (idx_reg),
        .wdata (mw_val),
        .re    (cmd.ld_idx),
        .raddr (idx_n),
        .rdata (ram_q)
    );

    assign mem_val = vld_reg[idx_reg] ? ram_q : '0;
    assign src     = (rb == 4'd0) ? imm : mem_val;
    assign a_abs   = a_reg[XL-1] ? (XL)'(-a_reg) : a_reg;
    assign s_abs   = src[XL-1] ? (XL)'(-src) : src;
    assign div_rs  = {rem_reg, quo_reg[XL-1]};
    assign div_res = neg_reg ? (XL)'(-quo_reg) : quo_reg;

    assign stat.need_calc = (op == tiie_pkg::OP_MUL) || (op == tiie_pkg::OP_DIV);
    assign stat.calc_last = cnt_reg == tiie_pkg::CNT_W'(XL - 1);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // execute and commit
    always_comb
    begin
        err    = 1'b0;
        halt   = 1'b0;
        ov     = 1'b0;
        oval   = '0;
        wr_en  = 1'b0;
        wr_val = '0;
        mw_en  = 1'b0;
        mw_val = '0;
        take   = 1'b0;
        flag_n = flag_reg;
        nip    = ip_reg + tiie_pkg::IP_W'(4);
        case (op)
            tiie_pkg::OP_MOVE:
            begin
                if (rb == 4'd0)
                begin
                    err    = ra_bad;
                    wr_en  = 1'b1;
                    wr_val = imm;
                end
                else if (rb >= 4'd5)
                begin
                    err    = ra_bad || rb_bad || !idx_ok_reg;
                    wr_en  = 1'b1;
                    wr_val = mem_val;
                end
                else
                begin
                    err    = ra_bad || !idx_ok_reg;
                    mw_en  = 1'b1;
                    mw_val = b_reg;
                end
            end
            tiie_pkg::OP_ADD, tiie_pkg::OP_SUB, tiie_pkg::OP_MUL, tiie_pkg::OP_DIV,
            tiie_pkg::OP_AND, tiie_pkg::OP_OR, tiie_pkg::OP_CMP:
            begin
                err   = ra_bad || ((rb != 4'd0) && (rb_bad || !idx_ok_reg));
                wr_en = 1'b1;
                case (op)
                    tiie_pkg::OP_ADD: wr_val = a_reg + src;
                    tiie_pkg::OP_SUB: wr_val = a_reg - src;
                    tiie_pkg::OP_MUL: wr_val = acc_reg;
                    tiie_pkg::OP_DIV:
                    begin
                        err    = err || (src == '0);
                        wr_val = div_res;
                    end
                    tiie_pkg::OP_AND: wr_val = XL'((a_reg != '0) && (src != '0));
                    tiie_pkg::OP_OR:  wr_val = XL'((a_reg != '0) || (src != '0));
                    default:
                    begin
                        wr_en = 1'b0;
                        if (a_reg == src)
                        begin
                            flag_n = tiie_pkg::FLAG_EQ;
                        end
                        else if ($signed(a_reg) > $signed(src))
                        begin
                            flag_n = tiie_pkg::FLAG_GT;
                        end
                        else
                        begin
                            flag_n = tiie_pkg::FLAG_LESS;
                        end
                    end
                endcase
            end
            tiie_pkg::OP_NOT:
            begin
                if (rb == 4'd0)
                begin
                    err    = ra_bad;
                    wr_en  = 1'b1;
                    wr_val = XL'(a_reg == '0);
                end
                else
                begin
                    err    = rb_bad || !idx_ok_reg;
                    mw_en  = 1'b1;
                    mw_val = XL'(mem_val == '0);
                end
            end
            tiie_pkg::OP_JMP:
            begin
                case (rb)
                    tiie_pkg::JC_ALWAYS: take = 1'b1;
                    tiie_pkg::JC_EQ:     take = flag_reg == tiie_pkg::FLAG_EQ;
                    tiie_pkg::JC_GT:     take = flag_reg == tiie_pkg::FLAG_GT;
                    default:             take = flag_reg == tiie_pkg::FLAG_LESS;
                endcase
                if (take)
                begin
                    nip = ip_reg + imm[tiie_pkg::IP_W-1:0];
                end
            end
            tiie_pkg::OP_IN:
            begin
                err    = ra_bad;
                wr_en  = 1'b1;
                wr_val = inval_reg;
            end
            tiie_pkg::OP_OUT:
            begin
                err  = ra_bad;
                ov   = !ra_bad;
                oval = ra_bad ? '0 : a_reg;
            end
            default: halt = 1'b1;
        endcase
        if (err)
        begin
            wr_en  = 1'b0;
            mw_en  = 1'b0;
            flag_n = flag_reg;
        end
        wr_en = wr_en && cmd.commit && (ra != 4'd0);
        mw_en = mw_en && cmd.commit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            ins_reg   <= s_tdata[XL-1:0];
            inval_reg <= s_tdata[2*XL-1:XL];
        end
        if (cmd.ld_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.ld_b)
        begin
            b_reg <= rdata;
        end
        if (cmd.ld_idx)
        begin
            idx_reg    <= idx_n;
            idx_ok_reg <= idx_ok_n;
        end
        if (cmd.calc_start)
        begin
            mcand_reg  <= a_reg;
            mplier_reg <= src;
            acc_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= a_abs;
            dvs_reg    <= s_abs;
            neg_reg    <= a_reg[XL-1] ^ src[XL-1];
        end
        else if (cmd.calc_step)
        begin
            acc_reg    <= acc_reg + (mplier_reg[0] ? mcand_reg : '0);
            mcand_reg  <= {mcand_reg[XL-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[XL-1:1]};
            if (div_rs >= {1'b0, dvs_reg})
            begin
                rem_reg <= XL'(div_rs - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[XL-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_rs[XL-1:0];
                quo_reg <= {quo_reg[XL-2:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            out_reg <= {3'b000, err, halt, oval, ov, flag_n, nip};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg       <= '0;
            flag_reg     <= '0;
            vld_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < tiie_pkg::NREGS; i++)
            begin
                gpr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.calc_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.calc_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                ip_reg       <= nip;
                flag_reg     <= flag_n;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                gpr_reg[rm1[2:0]] <= wr_val;
            end
            if (mw_en)
            begin
                vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed word not presented");
    a_ip_only_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(ip_reg) && $stable(flag_reg))
        else $error("architectural state changed outside commit");
    a_no_store_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && err) |-> !mw_en && !wr_en)
        else $error("state written on error");

endmodule

// ===== test/toy_isa_instruction_execute_unit_checker.sv =====
`timescale 1ns / 1ps

module toy_isa_instruction_execute_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          words_checked
);

    // first member sits in the highest bits
    typedef struct packed {
        logic        error;
        logic        halted;
        logic [31:0] out_value;
        logic        out_valid;
        logic [1:0]  flag;
        logic [15:0] next_ip;
    } exec_result_t;

    logic [tiie_pkg::IP_W-1:0]   cur_ip;
    logic [tiie_pkg::FLAG_W-1:0] cur_flag;
    logic [tiie_pkg::XLEN-1:0]   regs [1:tiie_pkg::NREGS];
    logic [tiie_pkg::XLEN-1:0]   mem [0:tiie_pkg::DATA_WORDS-1];
    exec_result_t                expected_q [$];

    function automatic bit read_reg(input int i, output logic [tiie_pkg::XLEN-1:0] v);
        v = '0;
        if (i == 0)
            return 1;
        if (i <= tiie_pkg::NREGS)
        begin
            v = regs[i];
            return 1;
        end
        return 0;
    endfunction

    function automatic void write_reg(input int i, input logic [tiie_pkg::XLEN-1:0] v);
        if (i >= 1 && i <= tiie_pkg::NREGS)
            regs[i] = v;
    endfunction

    function automatic bit mem_index(input int r, output int idx);
        logic [tiie_pkg::XLEN-1:0] v;
        longint q;
        idx = 0;
        if (!read_reg(r, v))
            return 0;
        q = (longint'($signed(v)) - tiie_pkg::DATA_BASE) / 2;
        if (q < 0 || q >= tiie_pkg::DATA_WORDS)
            return 0;
        idx = int'(q);
        return 1;
    endfunction

    function automatic exec_result_t execute(input logic [31:0] ins, input logic [31:0] inval);
        exec_result_t res;
        logic [7:0] op;
        int ra;
        int rb;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        int idx;
        bit err;
        bit take;
        op = ins[31:24];
        ra = ins[23:20];
        rb = ins[19:16];
        imm = {{16{ins[15]}}, ins[15:0]};
        a = '0;
        b = '0;
        err = 0;
        res = '0;
        res.next_ip = cur_ip + 16'd4;
        if (op == tiie_pkg::OP_MOVE)
        begin
            if (rb == 0)
            begin
                if (ra > tiie_pkg::NREGS) err = 1; else write_reg(ra, imm);
            end
            else if (rb >= 5)
            begin
                if (ra > tiie_pkg::NREGS || !mem_index(rb, idx)) err = 1;
                else write_reg(ra, mem[idx]);
            end
            else
            begin
                if (!mem_index(ra, idx) || !read_reg(rb, b)) err = 1;
                else mem[idx] = b;
            end
        end
        else if ((op >= tiie_pkg::OP_ADD && op <= tiie_pkg::OP_OR) || op == tiie_pkg::OP_CMP)
        begin
            if (!read_reg(ra, a)) err = 1;
            else if (rb == 0) b = imm;
            else if (!mem_index(rb, idx)) err = 1;
            else b = mem[idx];
            if (!err)
            begin
                case (op)
                    tiie_pkg::OP_ADD: write_reg(ra, a + b);
                    tiie_pkg::OP_SUB: write_reg(ra, a - b);
                    tiie_pkg::OP_MUL: write_reg(ra, a * b);
                    tiie_pkg::OP_DIV:
                    begin
                        if (b == 0) err = 1;
                        else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) write_reg(ra, a);
                        else write_reg(ra, $signed(a) / $signed(b));
                    end
                    tiie_pkg::OP_AND: write_reg(ra, (a != 0 && b != 0) ? 32'd1 : 32'd0);
                    tiie_pkg::OP_OR:  write_reg(ra, (a != 0 || b != 0) ? 32'd1 : 32'd0);
                    default:
                    begin
                        if ($signed(a) == $signed(b)) cur_flag = tiie_pkg::FLAG_EQ;
                        else if ($signed(a) > $signed(b)) cur_flag = tiie_pkg::FLAG_GT;
                        else cur_flag = tiie_pkg::FLAG_LESS;
                    end
                endcase
            end
        end
        else if (op == tiie_pkg::OP_NOT)
        begin
            if (rb == 0)
            begin
                if (!read_reg(ra, a)) err = 1;
                else write_reg(ra, (a == 0) ? 32'd1 : 32'd0);
            end
            else
            begin
                if (!mem_index(rb, idx)) err = 1;
                else mem[idx] = (mem[idx] == 0) ? 32'd1 : 32'd0;
            end
        end
        else if (op == tiie_pkg::OP_JMP)
        begin
            if (rb == tiie_pkg::JC_ALWAYS) take = 1;
            else if (rb == tiie_pkg::JC_EQ) take = (cur_flag == tiie_pkg::FLAG_EQ);
            else if (rb == tiie_pkg::JC_GT) take = (cur_flag == tiie_pkg::FLAG_GT);
            else take = (cur_flag == tiie_pkg::FLAG_LESS);
            if (take)
                res.next_ip = cur_ip + imm[15:0];
        end
        else if (op == tiie_pkg::OP_IN)
        begin
            if (ra > tiie_pkg::NREGS) err = 1; else write_reg(ra, inval);
        end
        else if (op == tiie_pkg::OP_OUT)
        begin
            if (!read_reg(ra, a)) err = 1;
            else
            begin
                res.out_valid = 1;
                res.out_value = a;
            end
        end
        else
            res.halted = 1;
        res.flag = cur_flag;
        res.error = err;
        cur_ip = res.next_ip;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t got;
        exec_result_t want;
        if (!rst_n)
        begin
            cur_ip = '0;
            cur_flag = tiie_pkg::FLAG_EQ;
            for (int k = 1; k <= tiie_pkg::NREGS; k++)
                regs[k] = '0;
            for (int k = 0; k < tiie_pkg::DATA_WORDS; k++)
                mem[k] = '0;
            expected_q.delete();
            fail_count = 0;
            words_checked = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[52:0];
                if (expected_q.size() == 0)
                begin
                    $error("result word with no instruction pending: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    words_checked++;
                    if (got.next_ip !== want.next_ip)
                    begin
                        $error("next_ip: expected %h, got %h", want.next_ip, got.next_ip);
                        fail_count++;
                    end
                    if (got.flag !== want.flag)
                    begin
                        $error("flag_value: expected %b, got %b", want.flag, got.flag);
                        fail_count++;
                    end
                    if (got.out_valid !== want.out_valid)
                    begin
                        $error("out_valid: expected %b, got %b", want.out_valid, got.out_valid);
                        fail_count++;
                    end
                    if (got.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %h, got %h", want.out_value, got.out_value);
                        fail_count++;
                    end
                    if (got.halted !== want.halted)
                    begin
                        $error("halted: expected %b, got %b", want.halted, got.halted);
                        fail_count++;
                    end
                    if (got.error !== want.error)
                    begin
                        $error("error: expected %b, got %b", want.error, got.error);
                        fail_count++;
                    end
                    if (m_tdata[55:53] !== 3'b000)
                    begin
                        $error("padding: expected 0, got %b", m_tdata[55:53]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(execute(s_tdata[31:0], s_tdata[63:32]));
        end
        pending = expected_q.size();
    end

endmodule

// ===== test/toy_isa_instruction_execute_unit_tb.sv =====
`timescale 1ns / 1ps

module toy_isa_instruction_execute_unit_tb;

    localparam int RANDOM_WORDS = 1600;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    int          fail_count;
    int          pending;
    int          words_checked;
    int          cycle_count;
    int          words_sent;
    bit          long_stall_req;

    toy_isa_instruction_execute_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    toy_isa_instruction_execute_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] encode(input logic [7:0] op, input int ra, input int rb,
                                           input int imm);
        return {op, ra[3:0], rb[3:0], imm[15:0]};
    endfunction

    // sender: one word per call, valid stays high between back-to-back words
    task automatic send_word(input logic [31:0] ins, input logic [31:0] inval, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {inval, ins};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_instruction();
        int r;
        int ra;
        int rb;
        logic [7:0] op;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom;
        ra = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        if (r < 25)
            return encode(tiie_pkg::OP_MOVE,
                          ($urandom_range(0, 19) == 0) ? ra : $urandom_range(1, 8), 0,
                          tiie_pkg::DATA_BASE - 8 + $urandom_range(0, 530));
        if (r < 35)
            op = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(13, 255));
        else
            op = 8'($urandom_range(tiie_pkg::OP_MOVE, tiie_pkg::OP_OUT));
        rb = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        return encode(op, ra, rb, $urandom_range(0, 65535));
    endfunction

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                long_stall_req = 0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60))
            begin
                if (mode == 0)
                    m_tready <= 1'b1;
                else if (mode == 1)
                    m_tready <= ($urandom_range(0, 3) != 0);
                else if (mode == 2)
                    m_tready <= ($urandom_range(0, 3) == 0);
                else
                    m_tready <= $urandom_range(0, 1);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int burst;
        int gap;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        cycle_count = 0;
        words_sent = 0;
        long_stall_req = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every opcode, error cases
        send_word(encode(tiie_pkg::OP_MOVE, 1, 0, 16'h7FFF), 0, 0);
        send_word(encode(tiie_pkg::OP_IN, 2, 0, 0), 32'h8000_0000, 0);
        send_word(encode(tiie_pkg::OP_MOVE, 3, 0, tiie_pkg::DATA_BASE), 0, 0);
        send_word(encode(tiie_pkg::OP_MOVE, 4, 0,
                         tiie_pkg::DATA_BASE + 2 * tiie_pkg::DATA_WORDS - 2), 0, 1);
        send_word(encode(tiie_pkg::OP_MOVE, 3, 1, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_MOVE, 5, 3, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_ADD, 5, 0, 16'h8000), 0, 2);
        send_word(encode(tiie_pkg::OP_SUB, 1, 3, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_MUL, 1, 0, 16'hFFFD), 0, 0);
        send_word(encode(tiie_pkg::OP_DIV, 1, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_DIV, 2, 0, 16'hFFFF), 0, 0);
        send_word(encode(tiie_pkg::OP_DIV, 1, 0, 16'hFFF9), 0, 0);
        send_word(encode(tiie_pkg::OP_AND, 1, 0, 5), 0, 0);
        send_word(encode(tiie_pkg::OP_OR, 6, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_NOT, 6, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_NOT, 0, 4, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_CMP, 2, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_JMP, 15, 3, 16'hFFF0), 0, 0);
        send_word(encode(tiie_pkg::OP_CMP, 0, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_JMP, 0, 1, 16'h0100), 0, 0);
        send_word(encode(tiie_pkg::OP_OUT, 2, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_OUT, 9, 0, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_MOVE, 15, 5, 0), 0, 0);
        send_word(encode(tiie_pkg::OP_MOVE, 6, 0, 16'h8000), 0, 0);
        send_word(encode(tiie_pkg::OP_MOVE, 7, 6, 0), 0, 0);
        send_word(32'h0000_0000, 0, 0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        drain();

        long_stall_req = 1;
        for (int i = 0; i < RANDOM_WORDS;)
        begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            for (int k = 0; k < burst && i < RANDOM_WORDS; k++, i++)
                send_word(random_instruction(), $urandom, (k == 0) ? gap : 0);
            if (i > 800 && i - burst <= 800)
                drain();
        end
        drain();
        repeat (50) @(posedge clk);

        $display("%0d instructions sent, %0d results checked: all opcodes, stops,", words_sent,
                 words_checked);
        $display("memory loads and stores, jumps, bad register, bad index and divide by zero");
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tiie_pkg.sv
hdl/tiie_ram.sv
hdl/tiie_ctrl.sv
hdl/tiie_dp.sv
hdl/toy_isa_instruction_execute_unit.sv
test/toy_isa_instruction_execute_unit_checker.sv
test/toy_isa_instruction_execute_unit_tb.sv
